// ----- hdl/gcdist_pkg.sv -----
// shared constants, widths and the arctangent table for the great circle distance unit
package gcdist_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;
  localparam int unsigned CORDIC_STEPS_DEF    = 24;

  localparam int unsigned LAT_W    = 24;
  localparam int unsigned LON_W    = 25;
  localparam int unsigned DEG_W    = 26;
  localparam int unsigned RADIUS_W = 24;
  localparam int unsigned DIST_W   = 26;
  localparam int unsigned ANG_W    = 32;
  localparam int unsigned Q_W      = 33;
  localparam int unsigned THETA_W  = 32;

  localparam logic signed [Q_W-1:0]   INV_GAIN     = 33'sd652032875;
  localparam logic [30:0]             TWO_PI_Q28   = 31'd1686629713;
  localparam logic [RADIUS_W-1:0]     RADIUS_RESET = 24'd6371010;

  // arctangent of 2^-i in binary turns, 2^32 per full turn
  function automatic logic [29:0] atan_turn(input int unsigned i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/gcdist_deg2turn.sv -----
// fixed-point degrees to binary turns, pipelined reciprocal division by 360
module gcdist_deg2turn import gcdist_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic signed [DEG_W-1:0] deg_i,
  output logic                    vld_o,
  output logic signed [ANG_W-1:0] ang_o
);

  localparam int unsigned SH    = ANG_W - ANGLE_FRAC_BITS;
  localparam int unsigned MAG_W = DEG_W - 1;
  localparam int unsigned K1    = MAG_W + 9;
  localparam int unsigned M1_W  = 26;
  localparam int unsigned P1_W  = MAG_W + M1_W;
  localparam int unsigned A_W   = P1_W - K1;
  localparam int unsigned M2_W  = SH + 10;
  localparam int unsigned P2_W  = SH + 19;
  localparam int unsigned W5    = 2 * SH + 20;
  localparam logic [M1_W-1:0] M1 = M1_W'(((64'd1 << K1) + 64'd359) / 64'd360);
  localparam logic [63:0] M2_FULL = ((64'd1 << (SH + 18)) + 64'd359) / 64'd360;
  localparam logic [M2_W-1:0] M2 = M2_W'(M2_FULL);
  localparam logic [W5-1:0] C180 = W5'(64'd180 * M2_FULL);

  logic [4:0] vld_q;

  logic signed [DEG_W-1:0] neg_deg;
  logic [MAG_W-1:0] mag_d, mag1_q, mag2_q, r_full;
  logic neg1_q, neg2_q, neg3_q, neg4_q;
  logic [P1_W-1:0] prod1_q;
  logic [A_W-1:0] a_w, a3_q, a4_q;
  logic [8:0] r3_q;
  logic [P2_W-1:0] prod2_q;
  logic [W5-1:0] sum5;
  logic [SH-1:0] q2;
  logic [A_W+SH+ANG_W-1:0] tpad;
  logic [ANG_W-1:0] t;
  logic signed [ANG_W-1:0] ang_q;

  assign neg_deg = -deg_i;
  assign mag_d   = deg_i[DEG_W-1] ? neg_deg[MAG_W-1:0] : deg_i[MAG_W-1:0];
  assign a_w     = prod1_q[P1_W-1:K1];
  assign r_full  = mag2_q - MAG_W'(a_w) * MAG_W'(360);
  assign sum5    = W5'({prod2_q, {SH{1'b0}}}) + C180;
  assign q2      = sum5[SH+18 +: SH];
  assign tpad    = {{ANG_W{1'b0}}, a4_q, q2};
  assign t       = tpad[ANG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      neg1_q  <= deg_i[DEG_W-1];
      prod1_q <= mag1_q * M1;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      a3_q    <= a_w;
      r3_q    <= r_full[8:0];
      neg3_q  <= neg2_q;
      prod2_q <= r3_q * M2;
      a4_q    <= a3_q;
      neg4_q  <= neg3_q;
      ang_q   <= neg4_q ? $signed(-t) : $signed(t);
    end
  end

  assign vld_o = vld_q[4];
  assign ang_o = ang_q;

endmodule

// ----- hdl/gcdist_sincos.sv -----
// rotation cordic, one cell per iteration, gives sine and cosine in q30
module gcdist_sincos import gcdist_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic signed [ANG_W-1:0] ang_i,
  output logic                    vld_o,
  output logic signed [Q_W-1:0]   sin_o,
  output logic signed [Q_W-1:0]   cos_o
);

  localparam int unsigned N = CORDIC_STEPS;

  logic signed [Q_W-1:0]   x_q [0:N];
  logic signed [Q_W-1:0]   y_q [0:N];
  logic signed [ANG_W-1:0] z_q [0:N];
  logic                    flip_q [0:N];
  logic                    vld_q [0:N];
  logic                    flip_in;
  logic                    vout_q;
  logic signed [Q_W-1:0]   sin_q, cos_q;

  // beyond a quarter turn: rotate by half a turn and negate the results
  assign flip_in = (ang_i > $signed(32'h4000_0000)) || (ang_i < $signed(32'hC000_0000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vout_q   <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      vout_q   <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= INV_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= flip_in ? {~ang_i[ANG_W-1], ang_i[ANG_W-2:0]} : ang_i;
      flip_q[0] <= flip_in;
      cos_q     <= flip_q[N] ? -x_q[N] : x_q[N];
      sin_q     <= flip_q[N] ? -y_q[N] : y_q[N];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [Q_W-1:0]   dx, dy;
    logic signed [ANG_W-1:0] at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({2'b00, atan_turn(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][ANG_W-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign vld_o = vout_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- hdl/gcdist_arccos.sv -----
// arccos in binary turns: square, bit-per-cell square root, then vectoring cordic
module gcdist_arccos import gcdist_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic signed [ANG_W-1:0] c_i,
  output logic                    vld_o,
  output logic [THETA_W-1:0]      theta_o
);

  localparam int unsigned N    = CORDIC_STEPS;
  localparam int unsigned SQ_N = 31;
  localparam int unsigned V_W  = 62;
  localparam int unsigned Z_W  = 33;
  localparam logic [V_W-1:0] ONE_SQ = {{(V_W-1){1'b0}}, 1'b1} << 60;

  logic signed [63:0]      sq_full;
  logic [60:0]             sq_q;
  logic signed [ANG_W-1:0] ca_q;
  logic                    va_q;

  logic [V_W-1:0]          iv_q [0:SQ_N];
  logic [V_W-1:0]          ir_q [0:SQ_N];
  logic signed [ANG_W-1:0] ic_q [0:SQ_N];
  logic                    ivld_q [0:SQ_N];

  logic signed [Q_W-1:0]   vx_q [0:N];
  logic signed [Q_W-1:0]   vy_q [0:N];
  logic signed [Z_W-1:0]   vz_q [0:N];
  logic                    vvld_q [0:N];

  logic signed [Q_W-1:0]   c_ext, root;
  logic [THETA_W-1:0]      theta_q;
  logic                    vout_q;

  assign sq_full = c_i * c_i;
  assign c_ext   = $signed({ic_q[SQ_N][ANG_W-1], ic_q[SQ_N]});
  assign root    = $signed(ir_q[SQ_N][Q_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= 1'b0;
      ivld_q[0] <= 1'b0;
      vvld_q[0] <= 1'b0;
      vout_q    <= 1'b0;
    end else if (en_i) begin
      va_q      <= vld_i;
      ivld_q[0] <= va_q;
      vvld_q[0] <= ivld_q[SQ_N];
      vout_q    <= vvld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= sq_full[60:0];
      ca_q    <= c_i;
      iv_q[0] <= ONE_SQ - V_W'(sq_q);
      ir_q[0] <= '0;
      ic_q[0] <= ca_q;
      // negative cosine: pre-rotate by a quarter turn
      if (c_ext < 0) begin
        vx_q[0] <= root;
        vy_q[0] <= -c_ext;
        vz_q[0] <= Z_W'(1) <<< 30;
      end else begin
        vx_q[0] <= c_ext;
        vy_q[0] <= root;
        vz_q[0] <= '0;
      end
      if (vz_q[N] < 0) begin
        theta_q <= '0;
      end else if (vz_q[N] > (Z_W'(1) <<< 31)) begin
        theta_q <= THETA_W'(1) << 31;
      end else begin
        theta_q <= vz_q[N][THETA_W-1:0];
      end
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int unsigned K = SQ_N - 1 - j;
    localparam logic [V_W-1:0] B = {{(V_W-1){1'b0}}, 1'b1} << (2 * K);
    logic [V_W-1:0] trial;
    logic           take;
    assign trial = ir_q[j] + B;
    assign take  = iv_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ivld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        ivld_q[j+1] <= ivld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ic_q[j+1] <= ic_q[j];
        iv_q[j+1] <= take ? iv_q[j] - trial : iv_q[j];
        ir_q[j+1] <= take ? (ir_q[j] >> 1) + B : ir_q[j] >> 1;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [Q_W-1:0] dx, dy;
    logic signed [Z_W-1:0] at;
    logic                  pos;
    assign dx  = vy_q[i] >>> i;
    assign dy  = vx_q[i] >>> i;
    assign at  = $signed({3'b000, atan_turn(i)});
    assign pos = vy_q[i] > 0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vvld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vvld_q[i+1] <= vvld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (pos) begin
          vx_q[i+1] <= vx_q[i] + dx;
          vy_q[i+1] <= vy_q[i] - dy;
          vz_q[i+1] <= vz_q[i] + at;
        end else begin
          vx_q[i+1] <= vx_q[i] - dx;
          vy_q[i+1] <= vy_q[i] + dy;
          vz_q[i+1] <= vz_q[i] - at;
        end
      end
    end
  end

  assign vld_o   = vout_q;
  assign theta_o = theta_q;

endmodule

// ----- hdl/great_circle_distance_unit.sv -----
// great circle distance by the spherical law of cosines, fully pipelined
// throughput: one point pair per cycle unless stalled; all stages advance together, and
//   a bubble at the pipe end lets new input in while a result waits in the output register
// reset: clears all stage valid bits and the output valid; sphere radius resets to 6371010 m
module great_circle_distance_unit import gcdist_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [LAT_W-1:0]    lat_a_i,
  input  logic signed [LON_W-1:0]    lon_a_i,
  input  logic signed [LAT_W-1:0]    lat_b_i,
  input  logic signed [LON_W-1:0]    lon_b_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [DIST_W-1:0]          distance_m_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [RADIUS_W-1:0]        sphere_radius_m_i
);

  logic en;
  logic [RADIUS_W-1:0] radius_q;

  logic in_vld_q;
  logic signed [DEG_W-1:0] la_q, lb_q, dl_q;

  logic v_ta, v_tb, v_td;
  logic signed [ANG_W-1:0] t_a, t_b, t_d;
  logic v_sa, v_sb, v_sd;
  logic signed [Q_W-1:0] sa, ca, sb, cb, sd, cd;

  logic signed [31:0] sa32, ca32, sb32, cb32, cd32;
  logic signed [63:0] prod_cc, prod_ss, prod_pc;
  logic signed [31:0] p_q, ss1_q, cd1_q, pc_q, ss2_q, sum_q;
  logic signed [32:0] s33;
  logic p1_vld_q, p2_vld_q, p3_vld_q;

  logic ac_vld;
  logic [THETA_W-1:0] theta;

  logic [55:0] m_q;
  logic [54:0] hi_d, hi_q;
  logic [62:0] lo_full;
  logic [30:0] lo_q;
  logic [55:0] t_sum;
  logic d1_vld_q, d2_vld_q;

  logic out_valid_q;
  logic [DIST_W-1:0] dist_q;

  // the pipe moves unless a finished result is stuck behind a full output register
  assign en          = !out_valid_q || out_ready_i || !d2_vld_q;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= sphere_radius_m_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
      p1_vld_q <= v_sa;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      d1_vld_q <= ac_vld;
      d2_vld_q <= d1_vld_q;
    end
  end

  // longitude difference is taken exactly in degree units
  always_ff @(posedge clk_i) begin
    if (en) begin
      la_q <= {{(DEG_W-LAT_W){lat_a_i[LAT_W-1]}}, lat_a_i};
      lb_q <= {{(DEG_W-LAT_W){lat_b_i[LAT_W-1]}}, lat_b_i};
      dl_q <= {lon_a_i[LON_W-1], lon_a_i} - {lon_b_i[LON_W-1], lon_b_i};
    end
  end

  gcdist_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_deg_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_vld_q), .deg_i(la_q), .vld_o(v_ta), .ang_o(t_a)
  );
  gcdist_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_deg_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_vld_q), .deg_i(lb_q), .vld_o(v_tb), .ang_o(t_b)
  );
  gcdist_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_deg_d (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_vld_q), .deg_i(dl_q), .vld_o(v_td), .ang_o(t_d)
  );

  gcdist_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_ta), .ang_i(t_a), .vld_o(v_sa), .sin_o(sa), .cos_o(ca)
  );
  gcdist_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_tb), .ang_i(t_b), .vld_o(v_sb), .sin_o(sb), .cos_o(cb)
  );
  gcdist_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_d (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_td), .ang_i(t_d), .vld_o(v_sd), .sin_o(sd), .cos_o(cd)
  );

  // the three lanes run in lockstep, lane b and d valids match lane a
  assign sa32 = (v_sb && v_sd) ? sa[31:0] : sa[31:0];
  assign ca32 = ca[31:0];
  assign sb32 = sb[31:0];
  assign cb32 = cb[31:0];
  assign cd32 = cd[31:0];

  assign prod_cc = ca32 * cb32;
  assign prod_ss = sa32 * sb32;
  assign prod_pc = p_q * cd1_q;
  assign s33     = $signed({ss2_q[31], ss2_q}) + $signed({pc_q[31], pc_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q   <= prod_cc[61:30];
      ss1_q <= prod_ss[61:30];
      cd1_q <= cd32;
      pc_q  <= prod_pc[61:30];
      ss2_q <= ss1_q;
      if (s33 > 33'sd1073741824) begin
        sum_q <= 32'sd1073741824;
      end else if (s33 < -33'sd1073741824) begin
        sum_q <= -32'sd1073741824;
      end else begin
        sum_q <= s33[31:0];
      end
    end
  end

  gcdist_arccos #(.CORDIC_STEPS(CORDIC_STEPS)) u_acos (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p3_vld_q), .c_i(sum_q), .vld_o(ac_vld), .theta_o(theta)
  );

  // radius times angle in turns, then scaled by two pi in q28
  assign hi_d    = m_q[55:32] * TWO_PI_Q28;
  assign lo_full = m_q[31:0] * TWO_PI_Q28;
  assign t_sum   = 56'(hi_q) + 56'(lo_q) + (56'd1 << 27);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q  <= radius_q * theta;
      hi_q <= hi_d;
      lo_q <= lo_full[62:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && d2_vld_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && d2_vld_q) begin
      dist_q <= t_sum[28 +: DIST_W];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_m_o = dist_q;

endmodule

// ----- sim/gcdist_checker.sv -----
// checker for the great circle distance unit: predicts distances and compares results
module gcdist_checker import gcdist_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [LAT_W-1:0] lat_a_i,
  input  logic signed [LON_W-1:0] lon_a_i,
  input  logic signed [LAT_W-1:0] lat_b_i,
  input  logic signed [LON_W-1:0] lon_b_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [DIST_W-1:0]       distance_m_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [RADIUS_W-1:0]     sphere_radius_m_i,
  output int                      pending_o,
  output int                      errors_o
);

  localparam longint Q_ONE = 64'sd1 << 30;

  logic [DIST_W-1:0] distance_q[$];
  logic [RADIUS_W-1:0] radius_q;

  // arithmetic shift right, rounding toward minus infinity
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_of(int i);
    longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  function automatic longint deg_turns(longint deg);
    longint unsigned denom, mag, q;
    logic [31:0] t;
    denom = 64'd360 << ANGLE_FRAC_BITS_DEF;
    mag = (deg < 0) ? -deg : deg;
    q = ((mag << 32) + denom / 2) / denom;
    t = q[31:0];
    if (deg < 0) t = 32'd0 - t;
    return longint'($signed(t));
  endfunction

  task automatic rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032875; y = 0; z = ang; flip = 0;
    if (z > (64'sd1 << 30)) begin
      z -= 64'sd1 << 31; flip = 1;
    end else if (z < -(64'sd1 << 30)) begin
      z += 64'sd1 << 31; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shr_floor(y, i); dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_of(i);
      end else begin
        x += dx; y -= dy; z += atan_of(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint arc_cos(longint c);
    longint x, y, z, t, dx, dy;
    z = 0;
    y = longint'(int_sqrt(longint'(Q_ONE * Q_ONE - c * c)));
    x = c;
    if (x < 0) begin
      t = x; x = y; y = -t; z = 64'sd1 << 30;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shr_floor(y, i); dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_of(i);
      end else begin
        x -= dx; y += dy; z -= atan_of(i);
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
    return z;
  endfunction

  task automatic predict_distance(input longint la, oa, lb, ob, output logic [DIST_W-1:0] d);
    longint sa, ca, sb, cb, sd, cd, p, sum, theta;
    longint unsigned m, t;
    rotate(deg_turns(la), sa, ca);
    rotate(deg_turns(lb), sb, cb);
    rotate(deg_turns(oa - ob), sd, cd);
    p = shr_floor(ca * cb, 30);
    sum = shr_floor(sa * sb, 30) + shr_floor(p * cd, 30);
    if (sum > Q_ONE) sum = Q_ONE;
    if (sum < -Q_ONE) sum = -Q_ONE;
    theta = arc_cos(sum);
    m = longint'(radius_q) * theta;
    t = (m >> 32) * 64'd1686629713 + (((m & 64'hFFFFFFFF) * 64'd1686629713) >> 32);
    t = (t + (64'd1 << 27)) >> 28;
    d = t[DIST_W-1:0];
  endtask

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
  end

  assign pending_o = distance_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DIST_W-1:0] d;
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      distance_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) radius_q <= sphere_radius_m_i;
      if (in_valid_i && in_ready_i) begin
        predict_distance(lat_a_i, lon_a_i, lat_b_i, lon_b_i, d);
        distance_q.push_back(d);
      end
      if (out_valid_i && out_ready_i) begin
        if (distance_q.size() == 0) report("result with nothing expected");
        else begin
          d = distance_q.pop_front();
          if (d !== distance_m_i)
            report($sformatf("distance got %0d expected %0d", distance_m_i, d));
        end
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// testbench top: stimulus, radius settings and verdict for the great circle distance unit
module testbench import gcdist_pkg::*;;

  localparam int LATENCY = 2 * CORDIC_STEPS_DEF + 49;
  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0, out_ready_i = 0, cfg_valid_i = 0;
  logic in_ready_o, out_valid_o, cfg_ready_o;
  logic signed [LAT_W-1:0] lat_a_i = '0, lat_b_i = '0;
  logic signed [LON_W-1:0] lon_a_i = '0, lon_b_i = '0;
  logic [RADIUS_W-1:0] sphere_radius_m_i = '0;
  logic [DIST_W-1:0] distance_m_o;
  int pending, errors;
  bit quiet = 0;
  bit long_stall = 0;

  always #4 clk_i = ~clk_i;

  great_circle_distance_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .lat_a_i, .lon_a_i, .lat_b_i, .lon_b_i,
    .out_valid_o, .out_ready_i, .distance_m_o, .cfg_valid_i, .cfg_ready_o, .sphere_radius_m_i
  );

  gcdist_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .lat_a_i, .lon_a_i, .lat_b_i,
    .lon_b_i, .out_valid_i(out_valid_o), .out_ready_i, .distance_m_i(distance_m_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .sphere_radius_m_i,
    .pending_o(pending), .errors_o(errors)
  );

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall) begin
        out_ready_i <= 0;
        repeat (400) @(negedge clk_i);
        long_stall = 0;
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk_i);
      end else out_ready_i <= 1;
    end
  end

  task automatic send_pair(input logic signed [LAT_W-1:0] la, input logic signed [LON_W-1:0] oa,
                           input logic signed [LAT_W-1:0] lb, input logic signed [LON_W-1:0] ob);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    lat_a_i <= la; lon_a_i <= oa; lat_b_i <= lb; lon_b_i <= ob;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic set_radius(input logic [RADIUS_W-1:0] r);
    cfg_valid_i <= 1;
    sphere_radius_m_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic signed [LAT_W-1:0] rnd_lat();
    case ($urandom_range(0, 3))
      0: return LAT_W'($urandom);
      1: return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
      default: return LAT_W'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endcase
  endfunction

  function automatic logic signed [LON_W-1:0] rnd_lon();
    case ($urandom_range(0, 3))
      0: return LON_W'($urandom);
      1: return $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
      default: return LON_W'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
    endcase
  endfunction

  initial begin
    logic signed [LAT_W-1:0] la;
    logic signed [LON_W-1:0] oa;
    logic [RADIUS_W-1:0] radii[4] = '{24'd6371010, 24'd0, 24'hFFFFFF, 24'd1};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: identical points, antipodes, poles, extremes, out of range angles
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, LON_MAX, 0, -LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
    send_pair(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
    send_pair(24'shFFFFFF, 25'sh1FFFFFF, 24'sh000001, 25'sh0000001);
    send_pair(LAT_MAX / 2, 0, LAT_MAX / 2, 1);
    send_pair(1, 1, 0, 0);
    send_pair(3000000, 5000000, -3000000, -6000000);
    send_pair(LAT_MAX - 1, 100, LAT_MAX, -100);
    send_pair(0, 5898240, 0, 0);
    send_pair(0, 5898241, 0, 0);
    send_pair(123456, -7777777, -654321, 8888888);
    foreach (radii[k]) begin
      drain();
      set_radius(radii[k]);
      for (int i = 0; i < 170; i++) begin
        if (i == 20 && k == 0) long_stall = 1;
        if ($urandom_range(0, 4) == 0) begin
          // nearby points keep the arccos argument near one
          la = rnd_lat(); oa = rnd_lon();
          send_pair(la, oa, la + LAT_W'($urandom_range(0, 64)) - 32,
                    oa + LON_W'($urandom_range(0, 64)) - 32);
        end else send_pair(rnd_lat(), rnd_lon(), rnd_lat(), rnd_lon());
      end
    end
    drain();
    set_radius(24'd6371010);
    quiet = 1;
    for (int i = 0; i < 60; i++) send_pair(rnd_lat(), rnd_lon(), rnd_lat(), rnd_lon());
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gcdist_pkg.sv
hdl/gcdist_deg2turn.sv
hdl/gcdist_sincos.sv
hdl/gcdist_arccos.sv
hdl/great_circle_distance_unit.sv
sim/gcdist_checker.sv
sim/testbench.sv
